[rtl/core/pcfc_pkg.sv]
// Shared types, constants and float helpers for the pixel channel format converter.
package pcfc_pkg;

	typedef enum logic [1:0] {
		FMT_U8     = 2'd0,
		FMT_U16    = 2'd1,
		FMT_HALF   = 2'd2,
		FMT_SINGLE = 2'd3
	} fmt_t;

	localparam logic REG_SRC_FMT = 1'b0;
	localparam logic REG_DST_FMT = 1'b1;

	// 255 is applied as 255*256 so both scales land the product at the same bit
	localparam logic [15:0] SCALE_U8_HI  = 16'hFF00;
	localparam logic [15:0] SCALE_U16    = 16'hFFFF;
	// ceil(2^24 / 257)
	localparam logic [15:0] RECIP_257    = 16'hFF01;
	localparam logic [9:0]  F2I_BIAS_U8  = 10'd143;
	localparam logic [9:0]  F2I_BIAS_U16 = 10'd135;
	localparam logic [15:0] MAX_U8       = 16'h00FF;
	localparam logic [15:0] MAX_U16      = 16'hFFFF;

	typedef struct packed {
		logic       sign;
		logic       nan;
		logic [7:0] exp;
		logic       to_u8;
	} f2i_ctrl_t;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] p;
		logic [9:0] mn;
		logic [7:0] e2;
		logic [31:0] r;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		p = '0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) p = 4'(i);
		end
		mn = m << (4'd10 - p);
		e2 = 8'd103 + {4'd0, p};
		if (e == 5'h1F) begin
			r = (m != '0) ? {s, 8'hFF, 1'b1, m[8:0], 13'd0} : {s, 8'hFF, 23'd0};
		end else if (e == 5'd0) begin
			r = (m == '0) ? {s, 31'd0} : {s, e2, mn, 13'd0};
		end else begin
			r = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
		end
		return r;
	endfunction

	function automatic logic [15:0] single_to_half(input logic [31:0] f);
		logic        s;
		logic [7:0]  e;
		logic [22:0] m;
		logic [14:0] h;
		logic [12:0] rem;
		logic [6:0]  sh;
		logic [23:0] full;
		logic [23:0] hs;
		logic [23:0] rm;
		logic [23:0] hw;
		logic [15:0] r;
		s = f[31];
		e = f[30:23];
		m = f[22:0];
		h = '0;
		rem = '0;
		sh = '0;
		full = {1'b1, m};
		hs = '0;
		rm = '0;
		hw = '0;
		if (e == 8'hFF) begin
			r = (m != '0) ? {s, 5'h1F, 1'b1, m[21:13]} : {s, 15'h7C00};
		end else if (e == 8'd0) begin
			r = {s, 15'd0};
		end else if (e > 8'd142) begin
			r = {s, 15'h7C00};
		end else if (e >= 8'd113) begin
			h = {5'(e - 8'd112), m[22:13]};
			rem = m[12:0];
			if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 15'd1;
			r = {s, h};
		end else begin
			sh = 7'(8'd126 - e);
			if (sh >= 7'd25) begin
				r = {s, 15'd0};
			end else begin
				hs = full >> sh;
				rm = full & ((24'd1 << sh) - 24'd1);
				hw = 24'd1 << (sh - 7'd1);
				if (rm > hw || (rm == hw && hs[0])) hs = hs + 24'd1;
				r = {s, hs[14:0]};
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] lead_zeros16(input logic [15:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) n = 4'(15 - i);
		end
		return n;
	endfunction

	function automatic logic [2:0] lead_zeros8(input logic [7:0] v);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) n = 3'(7 - i);
		end
		return n;
	endfunction

endpackage

[rtl/core/pcfc_f2i.sv]
// Float to unorm stage: round the scaled product, truncate and saturate.
module pcfc_f2i import pcfc_pkg::*; (
	input  logic [39:0] prod,
	input  f2i_ctrl_t   ctrl,
	output logic [15:0] value,
	output logic        clip
);
	logic        top;
	logic [23:0] kept;
	logic        rnd;
	logic        sticky;
	logic [24:0] rounded;
	logic [9:0]  k;
	logic        inf;
	logic        big;
	logic        zero;
	logic [24:0] mag;
	logic [15:0] maxv;

	always_comb begin
		top = prod[39];
		if (top) begin
			kept = prod[39:16];
			rnd = prod[15];
			sticky = |prod[14:0];
		end else begin
			kept = prod[38:15];
			rnd = prod[14];
			sticky = |prod[13:0];
		end
		rounded = {1'b0, kept} + {24'd0, rnd & (sticky | kept[0])};
		// right shift that leaves the integer part of the rounded product
		k = (ctrl.to_u8 ? F2I_BIAS_U8 : F2I_BIAS_U16) - {2'd0, ctrl.exp} - {9'd0, top};
		inf = (ctrl.exp == 8'hFF) && !ctrl.nan;
		big = inf || k[9] || (k == 10'd0);
		zero = (ctrl.exp == 8'd0) || (!k[9] && k >= 10'd25);
		mag = rounded >> k[4:0];
		maxv = ctrl.to_u8 ? MAX_U8 : MAX_U16;
		value = '0;
		clip = 1'b0;
		if (ctrl.nan) begin
			clip = 1'b1;
		end else if (ctrl.sign) begin
			clip = !zero && (big || mag != '0);
		end else if (big || (!zero && mag > {9'd0, maxv})) begin
			value = maxv;
			clip = 1'b1;
		end else if (!zero) begin
			value = mag[15:0];
		end
	end
endmodule

[rtl/core/pixel_channel_format_converter_core.sv]
// Pixel channel format converter: unorm8, unorm16, half and single, three-stage pipeline.
//  channel | valid    | stall     | payload
//  in      | in_valid | in_stall  | sample_bits
//  out     | out_valid| out_stall | result_bits, clipped
//  cfg     | cfg_we   | -         | cfg_index, cfg_wdata
// One transfer per cycle in each direction while no stall holds the pipeline; data is registered through s1, s2, s3.
// The 24x16 scale multiply in stage two sets the stage depth.
// arst_n clears valid bits and resets both formats to unorm8.
// A stall on the output fills empty stages first, then backs up to in_stall.
module pixel_channel_format_converter_core import pcfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample_bits,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits,
	output logic        clipped
);
	fmt_t src_fmt_q, dst_fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_U8;
			dst_fmt_q <= FMT_U8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_FMT: src_fmt_q <= fmt_t'(cfg_wdata);
				REG_DST_FMT: dst_fmt_q <= fmt_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3 = !v_s3 || !out_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: mask, widen half, set up the repeating fraction of x/255 or x/65535
	logic [31:0] x_a, fb_a;
	logic [2:0]  lz8_a;
	logic [3:0]  lz16_a;
	logic [15:0] dbl8_a;
	logic [31:0] dbl16_a;
	logic [31:0] stream_a;
	logic [7:0]  exp_a;
	logic        xzero_a;

	always_comb begin
		case (src_fmt_q)
			FMT_U8:     x_a = {24'd0, sample_bits[7:0]};
			FMT_SINGLE: x_a = sample_bits;
			default:    x_a = {16'd0, sample_bits[15:0]};
		endcase
		fb_a = (src_fmt_q == FMT_HALF) ? half_to_single(x_a[15:0]) : x_a;
		lz8_a = lead_zeros8(x_a[7:0]);
		lz16_a = lead_zeros16(x_a[15:0]);
		dbl8_a = {x_a[7:0], x_a[7:0]} << ({1'b0, lz8_a} + 4'd1);
		dbl16_a = {x_a[15:0], x_a[15:0]} << ({1'b0, lz16_a} + 5'd1);
		if (src_fmt_q == FMT_U8) begin
			stream_a = {dbl8_a[15:8], dbl8_a[15:8], dbl8_a[15:8], dbl8_a[15:8]};
			exp_a = 8'd126 - {5'd0, lz8_a};
		end else begin
			stream_a = {dbl16_a[31:16], dbl16_a[31:16]};
			exp_a = 8'd126 - {4'd0, lz16_a};
		end
		xzero_a = (x_a[15:0] == '0);
	end

	logic [31:0] x_s1, fb_s1;
	fmt_t        src_s1, dst_s1;
	logic [30:0] i2f_s1;
	logic        rnd_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1 <= x_a;
			fb_s1 <= fb_a;
			src_s1 <= src_fmt_q;
			dst_s1 <= dst_fmt_q;
			i2f_s1 <= xzero_a ? 31'd0 : {exp_a, stream_a[31:9]};
			rnd_s1 <= !xzero_a && stream_a[8];
		end
	end

	// stage 2: round the unorm-to-float value, scale multiply, divide by 257
	logic        src_int_b;
	logic [31:0] fsel_b;
	logic [23:0] sig_b;
	logic [15:0] scale_b;
	logic [39:0] prod_b;
	logic [31:0] q_b;

	always_comb begin
		src_int_b = (src_s1 == FMT_U8) || (src_s1 == FMT_U16);
		fsel_b = src_int_b ? {1'b0, i2f_s1 + {30'd0, rnd_s1}} : fb_s1;
		sig_b = {fb_s1[30:23] != 8'd0, fb_s1[22:0]};
		scale_b = (dst_s1 == FMT_U8) ? SCALE_U8_HI : SCALE_U16;
		prod_b = {16'd0, sig_b} * {24'd0, scale_b};
		q_b = {16'd0, x_s1[15:0]} * {16'd0, RECIP_257};
	end

	logic [31:0] x_s2, fsel_s2;
	logic [39:0] prod_s2;
	f2i_ctrl_t   ctrl_s2;
	fmt_t        src_s2, dst_s2;
	logic [7:0]  q_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			x_s2 <= x_s1;
			fsel_s2 <= fsel_b;
			prod_s2 <= prod_b;
			ctrl_s2.sign <= fb_s1[31];
			ctrl_s2.nan <= (fb_s1[30:23] == 8'hFF) && (fb_s1[22:0] != '0);
			ctrl_s2.exp <= fb_s1[30:23];
			ctrl_s2.to_u8 <= (dst_s1 == FMT_U8);
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
			q_s2 <= q_b[31:24];
		end
	end

	// stage 3: float-to-unorm, narrow to half, select the result
	logic [15:0] f2i_val_c;
	logic        f2i_clip_c;
	logic [31:0] res_c;
	logic        clip_c;
	logic        src_int_c, dst_int_c;

	pcfc_f2i u_f2i (
		.prod  (prod_s2),
		.ctrl  (ctrl_s2),
		.value (f2i_val_c),
		.clip  (f2i_clip_c)
	);

	always_comb begin
		src_int_c = (src_s2 == FMT_U8) || (src_s2 == FMT_U16);
		dst_int_c = (dst_s2 == FMT_U8) || (dst_s2 == FMT_U16);
		clip_c = 1'b0;
		if (src_s2 == dst_s2) begin
			res_c = x_s2;
		end else if (src_int_c && dst_int_c) begin
			res_c = (src_s2 == FMT_U8) ? {16'd0, x_s2[7:0], x_s2[7:0]} : {24'd0, q_s2};
		end else if (!dst_int_c) begin
			res_c = (dst_s2 == FMT_SINGLE) ? fsel_s2 : {16'd0, single_to_half(fsel_s2)};
			clip_c = !src_int_c && ctrl_s2.nan;
		end else begin
			res_c = {16'd0, f2i_val_c};
			clip_c = f2i_clip_c;
		end
	end

	logic [31:0] res_s3;
	logic        clip_s3;
	fmt_t        src_s3, dst_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			res_s3 <= res_c;
			clip_s3 <= clip_c;
			src_s3 <= src_s2;
			dst_s3 <= dst_s2;
		end
	end

	assign out_valid = v_s3;
	assign result_bits = res_s3;
	assign clipped = clip_s3;

`ifndef SYNTHESIS
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transfer did not reach stage 1");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy2 |=> v_s1 && $stable(x_s1))
		else $error("stage 1 lost or changed a held item");
	a_clip_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (src_s3 == FMT_HALF || src_s3 == FMT_SINGLE))
		else $error("clip flagged for an integer source");
	a_widen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && src_s3 == FMT_U8 && dst_s3 == FMT_U16
		|-> result_bits[15:8] == result_bits[7:0] && result_bits[31:16] == 16'd0)
		else $error("unorm8 widening result malformed");
`endif
endmodule
